FILE: design/stl_pkg.sv
// Package for the script token lexer: payload structs, token codes, constants.
// Used by every module in design/.
`default_nettype none
package stl_pkg;
    localparam int POS_BITS_DEF = 16;

    localparam logic [1:0] RK_TEXT  = 2'd0;
    localparam logic [1:0] RK_END   = 2'd1;
    localparam logic [1:0] RK_ERROR = 2'd2;

    localparam logic [4:0] TK_EOF    = 5'd0;
    localparam logic [4:0] TK_BAD    = 5'd1;
    localparam logic [4:0] TK_IDENT  = 5'd2;
    localparam logic [4:0] TK_KEYW   = 5'd3;
    localparam logic [4:0] TK_INT    = 5'd4;
    localparam logic [4:0] TK_FLOAT  = 5'd5;
    localparam logic [4:0] TK_STRING = 5'd6;
    localparam logic [4:0] TK_PLUS   = 5'd7;
    localparam logic [4:0] TK_MINUS  = 5'd8;
    localparam logic [4:0] TK_TIMES  = 5'd9;
    localparam logic [4:0] TK_DIVIDE = 5'd10;
    localparam logic [4:0] TK_ASSIGN = 5'd11;
    localparam logic [4:0] TK_EQUAL  = 5'd12;
    localparam logic [4:0] TK_GT     = 5'd13;
    localparam logic [4:0] TK_GE     = 5'd14;
    localparam logic [4:0] TK_LT     = 5'd15;
    localparam logic [4:0] TK_LE     = 5'd16;
    localparam logic [4:0] TK_NE     = 5'd17;
    localparam logic [4:0] TK_NOT    = 5'd18;
    localparam logic [4:0] TK_AND    = 5'd19;
    localparam logic [4:0] TK_OR     = 5'd20;
    localparam logic [4:0] TK_LPAREN = 5'd21;
    localparam logic [4:0] TK_RPAREN = 5'd22;
    localparam logic [4:0] TK_SEMI   = 5'd23;

    typedef enum logic [10:0] {
        S_START  = 11'b000_0000_0001,
        S_ID     = 11'b000_0000_0010,
        S_NUM    = 11'b000_0000_0100,
        S_FLOAT  = 11'b000_0000_1000,
        S_STR    = 11'b000_0001_0000,
        S_ASSIGN = 11'b000_0010_0000,
        S_GREAT  = 11'b000_0100_0000,
        S_LESS   = 11'b000_1000_0000,
        S_NOT    = 11'b001_0000_0000,
        S_AND    = 11'b010_0000_0000,
        S_OR     = 11'b100_0000_0000
    } t_scan_state;

    typedef struct packed {
        logic [7:0] input_byte;
        logic       end_of_input;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  text_char;
        logic [4:0]  token_kind;
        logic [2:0]  keyword_index;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic        last_of_run;
    } t_out_word;

    // one accepted input expands to up to three results, packed as a bundle
    typedef struct packed {
        logic [1:0]  count;
        t_out_word   r0;
        t_out_word   r1;
        t_out_word   r2;
    } t_bundle;

    localparam logic [47:0] KW_PRINT = 48'h0074_6e69_7270;
    localparam logic [47:0] KW_IF    = 48'h0000_0000_6669;
    localparam logic [47:0] KW_THEN  = 48'h0000_6e65_6874;
    localparam logic [47:0] KW_ELIF  = 48'h0000_6669_6c65;
    localparam logic [47:0] KW_ELSE  = 48'h0000_6573_6c65;
    localparam logic [47:0] KW_ENDIF = 48'h0066_6964_6e65;
    localparam logic [7:0]  CH_UNDER = 8'h5f;
    localparam logic [7:0]  CH_DOT   = 8'h2e;
endpackage
`default_nettype wire

FILE: design/stl_front.sv
// Front end of the script token lexer: scanner state machine, positions and
// keyword match; produces one result bundle per accepted word. Uses stl_pkg.
`default_nettype none
module stl_front #(
    parameter int POS_BITS = stl_pkg::POS_BITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire              i_cfg_data,
    input  wire              i_valid,
    input  wire stl_pkg::t_in_word i_word,
    output stl_pkg::t_bundle o_bundle
);
    localparam logic [POS_BITS-1:0] PMAX = {POS_BITS{1'b1}};

    stl_pkg::t_scan_state r_state, n_state;
    logic [7:0]          r_quote, n_quote;
    logic [POS_BITS-1:0] r_line, n_line, r_col, n_col, r_tline, n_tline, r_tcol, n_tcol;
    logic [47:0]         r_pre, n_pre;
    logic [2:0]          r_len, n_len;
    logic                r_halt, n_halt, r_first;

    stl_pkg::t_out_word res [3];
    logic [1:0] cnt;

    function automatic logic [15:0] clip(input logic [POS_BITS-1:0] v);
        if (POS_BITS > 16 && (v >> 16) != '0) return 16'hffff;
        return 16'(v);
    endfunction

    function automatic logic [POS_BITS-1:0] pinc(input logic [POS_BITS-1:0] v);
        return (v == PMAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [2:0] kw_lookup(input logic [47:0] p, input logic [2:0] l);
        if (l == 3'd5 && p == stl_pkg::KW_PRINT) return 3'd1;
        if (l == 3'd2 && p == stl_pkg::KW_IF)    return 3'd2;
        if (l == 3'd4 && p == stl_pkg::KW_THEN)  return 3'd3;
        if (l == 3'd4 && p == stl_pkg::KW_ELIF)  return 3'd4;
        if (l == 3'd4 && p == stl_pkg::KW_ELSE)  return 3'd5;
        if (l == 3'd5 && p == stl_pkg::KW_ENDIF) return 3'd6;
        return 3'd0;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic       again;
        logic [2:0] kw;
        stl_pkg::t_out_word w;
        logic [POS_BITS-1:0] pfirst;
        c = i_word.input_byte;
        pfirst = POS_BITS'(r_first);
        n_state = r_state; n_quote = r_quote; n_line = r_line; n_col = r_col;
        n_tline = r_tline; n_tcol = r_tcol; n_pre = r_pre; n_len = r_len;
        n_halt = r_halt;
        cnt = 2'd0;
        again = 1'b0;
        kw = kw_lookup(r_pre, r_len);
        for (int k = 0; k < 3; k++) res[k] = '0;
        if (!r_halt) begin
            if (i_word.end_of_input) begin
                w = '0;
                w.result_kind = stl_pkg::RK_END;
                w.start_line = clip(r_tline);
                w.start_column = clip(r_tcol);
                case (r_state)
                    stl_pkg::S_ID: begin
                        w.token_kind = (kw != 3'd0) ? stl_pkg::TK_KEYW : stl_pkg::TK_IDENT;
                        w.keyword_index = kw;
                    end
                    stl_pkg::S_NUM:    w.token_kind = stl_pkg::TK_INT;
                    stl_pkg::S_FLOAT:  w.token_kind = stl_pkg::TK_FLOAT;
                    stl_pkg::S_ASSIGN: w.token_kind = stl_pkg::TK_ASSIGN;
                    stl_pkg::S_GREAT:  w.token_kind = stl_pkg::TK_GT;
                    stl_pkg::S_LESS:   w.token_kind = stl_pkg::TK_LT;
                    stl_pkg::S_NOT:    w.token_kind = stl_pkg::TK_NOT;
                    default: ;
                endcase
                if (r_state == stl_pkg::S_STR || r_state == stl_pkg::S_AND
                        || r_state == stl_pkg::S_OR) begin
                    res[0] = '0;
                    res[0].result_kind = stl_pkg::RK_ERROR;
                    res[0].start_line = clip(r_line);
                    res[0].start_column = clip(r_col);
                    cnt = 2'd1;
                    n_halt = 1'b1;
                end else begin
                    if (r_state != stl_pkg::S_START) begin
                        res[0] = w;
                        cnt = 2'd1;
                    end
                    w = '0;
                    w.result_kind = stl_pkg::RK_END;
                    w.token_kind = stl_pkg::TK_EOF;
                    w.start_line = clip(r_line);
                    w.start_column = clip(r_col);
                    res[cnt] = w;
                    cnt = cnt + 2'd1;
                    n_tline = r_line; n_tcol = r_col;
                    n_state = stl_pkg::S_START;
                    n_line = pfirst; n_col = '0;
                    n_pre = '0; n_len = '0;
                end
            end else begin
                n_col = pinc(r_col);
                // first pass: state-specific handling; may ask for a replay in start
                w = '0;
                w.result_kind = stl_pkg::RK_END;
                w.start_line = clip(r_tline);
                w.start_column = clip(r_tcol);
                case (r_state)
                    stl_pkg::S_ID: begin
                        if (is_alpha(c) || is_digit(c) || c == stl_pkg::CH_UNDER) begin
                            if (r_len < 3'd6) n_pre = r_pre | (48'(c) << (8 * r_len));
                            if (r_len < 3'd7) n_len = r_len + 3'd1;
                            res[0].text_char = c; cnt = 2'd1;
                        end else begin
                            w.token_kind = (kw != 3'd0) ? stl_pkg::TK_KEYW : stl_pkg::TK_IDENT;
                            w.keyword_index = kw;
                            res[0] = w; cnt = 2'd1; again = 1'b1;
                        end
                    end
                    stl_pkg::S_NUM: begin
                        if (is_digit(c) || c == stl_pkg::CH_DOT) begin
                            res[0].text_char = c; cnt = 2'd1;
                            if (c == stl_pkg::CH_DOT) n_state = stl_pkg::S_FLOAT;
                        end else begin
                            w.token_kind = stl_pkg::TK_INT;
                            res[0] = w; cnt = 2'd1; again = 1'b1;
                        end
                    end
                    stl_pkg::S_FLOAT: begin
                        if (is_digit(c)) begin
                            res[0].text_char = c; cnt = 2'd1;
                        end else begin
                            w.token_kind = stl_pkg::TK_FLOAT;
                            res[0] = w; cnt = 2'd1; again = 1'b1;
                        end
                    end
                    stl_pkg::S_STR: begin
                        if (c != r_quote) begin
                            res[0].text_char = c; cnt = 2'd1;
                        end else begin
                            w.token_kind = stl_pkg::TK_STRING;
                            res[0] = w; cnt = 2'd1;
                            n_state = stl_pkg::S_START;
                        end
                    end
                    stl_pkg::S_ASSIGN, stl_pkg::S_GREAT, stl_pkg::S_LESS,
                    stl_pkg::S_NOT: begin
                        n_state = stl_pkg::S_START;
                        if (c == 8'h3d) begin
                            res[0].text_char = c;
                            case (r_state)
                                stl_pkg::S_ASSIGN: w.token_kind = stl_pkg::TK_EQUAL;
                                stl_pkg::S_GREAT:  w.token_kind = stl_pkg::TK_GE;
                                stl_pkg::S_LESS:   w.token_kind = stl_pkg::TK_LE;
                                default:           w.token_kind = stl_pkg::TK_NE;
                            endcase
                            res[1] = w; cnt = 2'd2;
                        end else begin
                            case (r_state)
                                stl_pkg::S_ASSIGN: w.token_kind = stl_pkg::TK_ASSIGN;
                                stl_pkg::S_GREAT:  w.token_kind = stl_pkg::TK_GT;
                                stl_pkg::S_LESS:   w.token_kind = stl_pkg::TK_LT;
                                default:           w.token_kind = stl_pkg::TK_NOT;
                            endcase
                            res[0] = w; cnt = 2'd1; again = 1'b1;
                        end
                    end
                    stl_pkg::S_AND, stl_pkg::S_OR: begin
                        if (c == ((r_state == stl_pkg::S_AND) ? 8'h26 : 8'h7c)) begin
                            res[0].text_char = c;
                            w.token_kind = (r_state == stl_pkg::S_AND) ? stl_pkg::TK_AND
                                                                      : stl_pkg::TK_OR;
                            res[1] = w; cnt = 2'd2;
                            n_state = stl_pkg::S_START;
                        end else begin
                            res[0].result_kind = stl_pkg::RK_ERROR;
                            res[0].start_line = clip(r_line);
                            res[0].start_column = clip(n_col);
                            cnt = 2'd1; n_halt = 1'b1;
                        end
                    end
                    default: again = 1'b1;
                endcase
                // start-state pass, run directly or as the replay
                if (again) begin
                    n_state = stl_pkg::S_START;
                    n_tline = r_line; n_tcol = n_col;
                    w = '0;
                    w.result_kind = stl_pkg::RK_END;
                    w.start_line = clip(r_line);
                    w.start_column = clip(n_col);
                    if (c == 8'h20 || c == 8'h09) begin
                    end else if (c == 8'h0a) begin
                        n_line = pinc(r_line); n_col = '0;
                    end else if (is_alpha(c)) begin
                        n_state = stl_pkg::S_ID;
                        n_pre = 48'(c); n_len = 3'd1;
                        res[cnt] = '0; res[cnt].text_char = c; cnt = cnt + 2'd1;
                    end else if (is_digit(c)) begin
                        n_state = stl_pkg::S_NUM;
                        res[cnt] = '0; res[cnt].text_char = c; cnt = cnt + 2'd1;
                    end else if (c == 8'h27 || c == 8'h22) begin
                        n_state = stl_pkg::S_STR; n_quote = c;
                    end else begin
                        res[cnt] = '0; res[cnt].text_char = c; cnt = cnt + 2'd1;
                        w.token_kind = stl_pkg::TK_EOF;
                        case (c)
                            8'h2b: w.token_kind = stl_pkg::TK_PLUS;
                            8'h2d: w.token_kind = stl_pkg::TK_MINUS;
                            8'h2a: w.token_kind = stl_pkg::TK_TIMES;
                            8'h2f: w.token_kind = stl_pkg::TK_DIVIDE;
                            8'h3d: n_state = stl_pkg::S_ASSIGN;
                            8'h3e: n_state = stl_pkg::S_GREAT;
                            8'h3c: n_state = stl_pkg::S_LESS;
                            8'h21: n_state = stl_pkg::S_NOT;
                            8'h26: n_state = stl_pkg::S_AND;
                            8'h7c: n_state = stl_pkg::S_OR;
                            8'h28: w.token_kind = stl_pkg::TK_LPAREN;
                            8'h29: w.token_kind = stl_pkg::TK_RPAREN;
                            8'h3b: w.token_kind = stl_pkg::TK_SEMI;
                            default: w.token_kind = stl_pkg::TK_BAD;
                        endcase
                        if (n_state == stl_pkg::S_START) begin
                            res[cnt] = w; cnt = cnt + 2'd1;
                        end
                    end
                end
            end
        end
        if (cnt != 2'd0) res[cnt - 2'd1].last_of_run = 1'b1;
    end

    assign o_bundle.count = cnt;
    assign o_bundle.r0 = res[0];
    assign o_bundle.r1 = res[1];
    assign o_bundle.r2 = res[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stl_pkg::S_START;
            r_quote <= '0;
            r_line  <= POS_BITS'(1);
            r_col   <= '0;
            r_tline <= '0;
            r_tcol  <= '0;
            r_pre   <= '0;
            r_len   <= '0;
            r_halt  <= 1'b0;
            r_first <= 1'b1;
        end else if (i_cfg_we) begin
            r_first <= i_cfg_data;
            r_line  <= POS_BITS'(i_cfg_data);
        end else if (i_valid) begin
            r_state <= n_state;
            r_quote <= n_quote;
            r_line  <= n_line;
            r_col   <= n_col;
            r_tline <= n_tline;
            r_tcol  <= n_tcol;
            r_pre   <= n_pre;
            r_len   <= n_len;
            r_halt  <= n_halt;
        end
    end

`ifndef ASSERT_OFF
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt cleared");
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> cnt == 2'd0) else $error("results while halted");
    a_state_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
`endif
endmodule
`default_nettype wire

FILE: design/stl_back.sv
// Back end of the script token lexer: bundle queue and result unpacker that
// streams results one per pop. Uses stl_pkg.
`default_nettype none
module stl_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire stl_pkg::t_bundle i_bundle,
    output logic              o_full,
    output logic              o_empty,
    input  wire               i_pop,
    output stl_pkg::t_out_word o_word
);
    localparam int DEPTH = 4;

    stl_pkg::t_bundle r_mem [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] r_sub;
    stl_pkg::t_bundle head;
    logic wr, rd;

    assign head = r_mem[r_rp];
    assign o_full = (r_cnt == 3'(DEPTH));
    assign o_empty = (r_cnt == 3'd0);
    assign wr = i_push && !o_full && (i_bundle.count != 2'd0);
    assign rd = i_pop && !o_empty && (r_sub == head.count - 2'd1);

    always_comb begin
        case (r_sub)
            2'd0: o_word = head.r0;
            2'd1: o_word = head.r1;
            default: o_word = head.r2;
        endcase
        n_cnt = r_cnt + 3'(wr) - 3'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_sub <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) begin
                r_rp <= r_rp + 2'd1;
                r_sub <= '0;
            end else if (i_pop && !o_empty) begin
                r_sub <= r_sub + 2'd1;
            end
            r_cnt <= n_cnt;
        end
    end

`ifndef ASSERT_OFF
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(DEPTH)) else $error("queue overflow");
    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> r_sub < head.count) else $error("sub index past bundle");
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd |-> o_word.last_of_run) else $error("bundle end without last flag");
`endif
endmodule
`default_nettype wire

FILE: design/script_token_lexer_core.sv
// Script token lexer top level. A pushed word's results are registered into the
// queue as a bundle; empty falls with that write. Throughput: one input word per
// cycle; a word yields up to three results, drained one per pop from a 4-bundle
// queue, so bursts of 2-3 results throttle input while the queue is full.
// Reset: synchronous active low; clears scanner, queue and sets line base to 1.
`default_nettype none
module script_token_lexer_core #(
    parameter int POS_BITS = stl_pkg::POS_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire                i_cfg_data,
    input  wire                push,
    output logic               full,
    input  wire stl_pkg::t_in_word i_in,
    output logic               empty,
    input  wire                pop,
    output stl_pkg::t_out_word o_out
);
    stl_pkg::t_bundle bundle;
    logic acc;

    assign acc = push && !full;

    stl_front #(.POS_BITS(POS_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(acc), .i_word(i_in), .o_bundle(bundle)
    );

    stl_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(acc), .i_bundle(bundle),
        .o_full(full), .o_empty(empty), .i_pop(pop), .o_word(o_out)
    );
endmodule
`default_nettype wire
